@@ design/rhs_pkg.sv @@
// Shared types and constants for the RTP header stripper.
// Used by rhs_in_stage, rhs_core and rtp_header_stripper_top; no dependencies.
package rhs_pkg;

    localparam int MAX_DATAGRAM = 2048;
    localparam int POS_W = $clog2(MAX_DATAGRAM + 1);

    localparam int BYTE_W = 8;
    localparam int CNT_W = 12;
    localparam int HDR_W = 7;
    localparam int TYPE_W = 7;
    localparam int VER_W = 2;

    localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(2048);
    localparam logic [CNT_W-1:0] MAX_LEN_RST = CNT_W'(2048);
    localparam logic [TYPE_W-1:0] EXPECT_TYPE_RST = TYPE_W'(33);
    localparam logic [HDR_W-1:0] FIXED_HDR_LEN = HDR_W'(12);
    localparam logic [VER_W-1:0] VERSION_OK = VER_W'(2);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXP_TYPE = 1'b1;
    localparam int CFG_DATA_W = 12;

    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } rhs_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  max_payload_length;
        logic [TYPE_W-1:0] expected_payload_type;
    } rhs_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  payload_count;
        logic              short_packet;
        logic              truncated;
        logic              type_bad;
        logic              version_bad;
        logic              end_of_packet;
        logic              byte_valid;
        logic [BYTE_W-1:0] payload_byte;
    } rhs_result_t;

endpackage

@@ design/rhs_in_stage.sv @@
// Input register of the RTP header stripper: holds one item from the slave stream.
// Depends on rhs_pkg.
module rhs_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rhs_pkg::rhs_item_t in_item,
    output logic              item_valid,
    input  logic              item_take,
    output rhs_pkg::rhs_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    rhs_pkg::rhs_item_t item_reg;

    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

@@ design/rhs_core.sv @@
// Packet state, header strip and length limit logic with the result register.
// Depends on rhs_pkg.
module rhs_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  rhs_pkg::rhs_cfg_t   cfg,
    input  logic                item_valid,
    output logic                item_take,
    input  rhs_pkg::rhs_item_t  item,
    output logic                res_valid,
    input  logic                res_ready,
    output rhs_pkg::rhs_result_t res
);

    logic [rhs_pkg::POS_W-1:0]  pos_reg;
    logic [rhs_pkg::POS_W-1:0]  pos_next;
    logic [rhs_pkg::HDR_W-1:0]  hdr_reg;
    logic [rhs_pkg::HDR_W-1:0]  hdr_next;
    logic [rhs_pkg::VER_W-1:0]  ver_reg;
    logic [rhs_pkg::VER_W-1:0]  ver_next;
    logic [rhs_pkg::TYPE_W-1:0] type_reg;
    logic [rhs_pkg::TYPE_W-1:0] type_next;
    logic [rhs_pkg::CNT_W-1:0]  fwd_reg;
    logic [rhs_pkg::CNT_W-1:0]  fwd_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       res_valid_reg;
    logic                       res_valid_next;
    rhs_pkg::rhs_result_t       res_reg;
    rhs_pkg::rhs_result_t       res_next;

    logic                       in_range;
    logic                       at_zero;
    logic                       payload_zone;
    logic                       below_limit;
    logic                       emit;
    logic [rhs_pkg::CNT_W-1:0]  limit;
    logic [rhs_pkg::HDR_W-1:0]  hdr_eff;
    logic [rhs_pkg::VER_W-1:0]  ver_eff;
    logic [rhs_pkg::TYPE_W-1:0] type_eff;
    logic [rhs_pkg::POS_W-1:0]  pos_eff;
    logic [rhs_pkg::CNT_W-1:0]  fwd_eff;
    logic                       ovf_eff;

    assign item_take = item_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        limit = (cfg.max_payload_length > rhs_pkg::LIMIT_CAP) ? rhs_pkg::LIMIT_CAP
                                                              : cfg.max_payload_length;
        in_range = pos_reg < rhs_pkg::POS_W'(rhs_pkg::MAX_DATAGRAM);
        at_zero = in_range && (pos_reg == '0);
        hdr_eff = at_zero ? rhs_pkg::FIXED_HDR_LEN + rhs_pkg::HDR_W'({item.in_byte[3:0], 2'b00})
                          : hdr_reg;
        ver_eff = at_zero ? item.in_byte[7:6] : ver_reg;
        type_eff = (in_range && (pos_reg == rhs_pkg::POS_W'(1))) ? item.in_byte[6:0]
                                                                 : type_reg;
        payload_zone = in_range && (pos_reg >= rhs_pkg::POS_W'(hdr_eff));
        below_limit = fwd_reg < limit;
        emit = payload_zone && below_limit;
        ovf_eff = ovf_reg || (payload_zone && !below_limit);
        fwd_eff = fwd_reg + rhs_pkg::CNT_W'(emit);
        pos_eff = in_range ? pos_reg + rhs_pkg::POS_W'(1) : pos_reg;

        res_next = '0;
        if (emit)
        begin
            res_next.payload_byte = item.in_byte;
            res_next.byte_valid = 1'b1;
        end
        if (item.in_last)
        begin
            res_next.end_of_packet = 1'b1;
            res_next.version_bad = ver_eff != rhs_pkg::VERSION_OK;
            res_next.type_bad = type_eff != cfg.expected_payload_type;
            res_next.truncated = ovf_eff;
            res_next.short_packet = pos_eff < rhs_pkg::POS_W'(hdr_eff);
            res_next.payload_count = fwd_eff;
        end

        pos_next = pos_reg;
        hdr_next = hdr_reg;
        ver_next = ver_reg;
        type_next = type_reg;
        fwd_next = fwd_reg;
        ovf_next = ovf_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (item_take)
        begin
            res_valid_next = emit || item.in_last;
            if (item.in_last)
            begin
                pos_next = '0;
                hdr_next = rhs_pkg::FIXED_HDR_LEN;
                ver_next = '0;
                type_next = '0;
                fwd_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                pos_next = pos_eff;
                hdr_next = hdr_eff;
                ver_next = ver_eff;
                type_next = type_eff;
                fwd_next = fwd_eff;
                ovf_next = ovf_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hdr_reg <= rhs_pkg::FIXED_HDR_LEN;
            ver_reg <= '0;
            type_reg <= '0;
            fwd_reg <= '0;
            ovf_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            ver_reg <= ver_next;
            type_reg <= type_next;
            fwd_reg <= fwd_next;
            ovf_reg <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

`ifndef NO_ASSERTIONS
    a_mid_result_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.end_of_packet |-> res_reg.byte_valid)
        else $error("result without payload byte before end of packet");

    a_short_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.short_packet |-> res_reg.payload_count == '0)
        else $error("short packet reports forwarded bytes");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg <= rhs_pkg::LIMIT_CAP)
        else $error("forwarded count beyond cap");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item.in_last |=> pos_reg == '0 && fwd_reg == '0 && !ovf_reg)
        else $error("packet state not cleared after final item");
`endif

endmodule

@@ design/rtp_header_stripper_top.sv @@
// Top level of the RTP header stripper: configuration registers and stream ports.
// Depends on rhs_pkg, rhs_in_stage and rhs_core.
//
// Usage: datagram bytes enter one item per cycle on the s_ stream while
// s_tready is high, s_tlast on the final byte. Header bytes (12 plus 4 per CSRC)
// are consumed without a result; each forwarded payload byte gives one item on
// the m_ stream, and the final byte always gives one item with m_tlast high that
// carries the status flags and the forwarded byte count.
// An accepted item is loaded into the input register and then moves through the
// strip logic into the result register, which drives m_tvalid.
// Throughput is one item per cycle; both stages advance together, so a new item
// is taken while a finished result waits as long as the result can leave.
// If the receiver holds m_tready low, the result register holds its item and
// the input register fills, after which s_tready drops until m_tready returns.
// The configuration channel is always ready and writes max_payload_length
// (index 0) or expected_payload_type (index 1); write only while idle.
// Reset clears both stages and the packet state and loads 2048 and 33 into the
// configuration registers.
module rtp_header_stripper_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rhs_pkg::BYTE_W-1:0]          s_tdata,   // in_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // payload_byte[7:0], byte_valid, version_bad, type_bad, truncated,
    // short_packet, payload_count[11:0], zero fill.
    output logic [rhs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rhs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rhs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rhs_pkg::rhs_cfg_t    cfg_reg;
    rhs_pkg::rhs_cfg_t    cfg_next;
    rhs_pkg::rhs_item_t   s_item;
    rhs_pkg::rhs_item_t   stage_item;
    logic                 stage_valid;
    logic                 stage_take;
    rhs_pkg::rhs_result_t res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rhs_pkg::CFG_IDX_MAX_LEN:
                begin
                    cfg_next.max_payload_length = cfg_data;
                end
                rhs_pkg::CFG_IDX_EXP_TYPE:
                begin
                    cfg_next.expected_payload_type = cfg_data[rhs_pkg::TYPE_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload_length <= rhs_pkg::MAX_LEN_RST;
            cfg_reg.expected_payload_type <= rhs_pkg::EXPECT_TYPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_item.in_byte = s_tdata;
    assign s_item.in_last = s_tlast;

    rhs_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .item_valid (stage_valid),
        .item_take  (stage_take),
        .item       (stage_item)
    );

    rhs_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (stage_valid),
        .item_take  (stage_take),
        .item       (stage_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tlast = res.end_of_packet;
    assign m_tdata = {7'b0, res.payload_count, res.short_packet, res.truncated,
                      res.type_bad, res.version_bad, res.byte_valid, res.payload_byte};

endmodule

@@ test/rtp_header_stripper_top_tb.sv @@
// Self-checking testbench for rtp_header_stripper_top: streams RTP datagrams byte by byte
// and compares each output item with a built-in header-strip predictor.
// Depends on rhs_pkg and rtp_header_stripper_top.
module rtp_header_stripper_top_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_BYTES = 265;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rhs_pkg::BYTE_W-1:0]       s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rhs_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                             m_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [rhs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [rhs_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    rhs_pkg::rhs_item_t   datagram_bytes[$];
    rhs_pkg::rhs_result_t payload_status_q[$];
    rhs_pkg::rhs_result_t mon_want;

    int sender_gap_pct = 0;
    int reader_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    logic [rhs_pkg::CNT_W-1:0]  cfg_max_len = rhs_pkg::MAX_LEN_RST;
    logic [rhs_pkg::TYPE_W-1:0] cfg_exp_type = rhs_pkg::EXPECT_TYPE_RST;
    logic [rhs_pkg::CNT_W-1:0]  pos = '0;
    logic [rhs_pkg::HDR_W-1:0]  hdr_len = rhs_pkg::FIXED_HDR_LEN;
    logic [rhs_pkg::VER_W-1:0]  ver = '0;
    logic [rhs_pkg::TYPE_W-1:0] ptype = '0;
    logic [rhs_pkg::CNT_W-1:0]  fwd = '0;
    logic                       ovf = 1'b0;

    logic [rhs_pkg::CNT_W-1:0]  run_len;
    logic [rhs_pkg::TYPE_W-1:0] run_type;

    rtp_header_stripper_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic strip_byte(input logic [rhs_pkg::BYTE_W-1:0] b, input logic last);
        rhs_pkg::rhs_result_t      r;
        logic                      emit;
        logic [rhs_pkg::CNT_W-1:0] lim;
        r = '0;
        emit = 1'b0;
        lim = (cfg_max_len > rhs_pkg::LIMIT_CAP) ? rhs_pkg::LIMIT_CAP : cfg_max_len;
        if (pos < rhs_pkg::MAX_DATAGRAM)
        begin
            if (pos == 0)
            begin
                ver = b[7:6];
                hdr_len = rhs_pkg::FIXED_HDR_LEN + rhs_pkg::HDR_W'({b[3:0], 2'b00});
            end
            else if (pos == 1)
            begin
                ptype = b[rhs_pkg::TYPE_W-1:0];
            end
            if (pos >= hdr_len)
            begin
                if (fwd < lim)
                begin
                    fwd = fwd + 1'b1;
                    emit = 1'b1;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
            pos = pos + 1'b1;
        end
        if (emit || last)
        begin
            if (emit)
            begin
                r.payload_byte = b;
                r.byte_valid = 1'b1;
            end
            if (last)
            begin
                r.end_of_packet = 1'b1;
                r.version_bad = (ver != rhs_pkg::VERSION_OK);
                r.type_bad = (ptype != cfg_exp_type);
                r.truncated = ovf;
                r.short_packet = (pos < hdr_len);
                r.payload_count = fwd;
                pos = '0;
                hdr_len = rhs_pkg::FIXED_HDR_LEN;
                ver = '0;
                ptype = '0;
                fwd = '0;
                ovf = 1'b0;
            end
            payload_status_q.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rhs_pkg::CFG_IDX_MAX_LEN)
                    cfg_max_len = cfg_data;
                else
                    cfg_exp_type = cfg_data[rhs_pkg::TYPE_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                strip_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready)
            begin
                if (datagram_bytes.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct)
                begin
                    s_tdata <= datagram_bytes[0].in_byte;
                    s_tlast <= datagram_bytes[0].in_last;
                    void'(datagram_bytes.pop_front());
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (payload_status_q.size() == 0)
                begin
                    report_mismatch("unexpected item, tdata", m_tdata, 32'd0);
                end
                else
                begin
                    mon_want = payload_status_q.pop_front();
                    if (m_tdata[7:0] != mon_want.payload_byte)
                        report_mismatch("payload_byte", 32'(m_tdata[7:0]),
                                        32'(mon_want.payload_byte));
                    if (m_tdata[8] != mon_want.byte_valid)
                        report_mismatch("byte_valid", 32'(m_tdata[8]),
                                        32'(mon_want.byte_valid));
                    if (m_tlast != mon_want.end_of_packet)
                        report_mismatch("end_of_packet", 32'(m_tlast),
                                        32'(mon_want.end_of_packet));
                    if (m_tdata[9] != mon_want.version_bad)
                        report_mismatch("version_bad", 32'(m_tdata[9]),
                                        32'(mon_want.version_bad));
                    if (m_tdata[10] != mon_want.type_bad)
                        report_mismatch("type_bad", 32'(m_tdata[10]),
                                        32'(mon_want.type_bad));
                    if (m_tdata[11] != mon_want.truncated)
                        report_mismatch("truncated", 32'(m_tdata[11]),
                                        32'(mon_want.truncated));
                    if (m_tdata[12] != mon_want.short_packet)
                        report_mismatch("short_packet", 32'(m_tdata[12]),
                                        32'(mon_want.short_packet));
                    if (m_tdata[24:13] != mon_want.payload_count)
                        report_mismatch("payload_count", 32'(m_tdata[24:13]),
                                        32'(mon_want.payload_count));
                    if (m_tdata[31:25] != '0)
                        report_mismatch("fill bits", 32'(m_tdata[31:25]), 32'd0);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= reader_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_byte(input logic [rhs_pkg::BYTE_W-1:0] b, input logic last);
        rhs_pkg::rhs_item_t it;
        it.in_byte = b;
        it.in_last = last;
        datagram_bytes.push_back(it);
    endtask

    task automatic write_reg(input logic [rhs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rhs_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (datagram_bytes.size() > 0 || s_tvalid || payload_status_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random_traffic(input logic [rhs_pkg::TYPE_W-1:0] want_type,
                                        input int quota);
        int kind;
        int csrc;
        int total;
        int i;
        int queued;
        logic [rhs_pkg::BYTE_W-1:0] b;
        queued = 0;
        while (queued < quota)
        begin
            kind = $urandom_range(0, 99);
            csrc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            total = 12 + 4 * csrc + $urandom_range(0, 24);
            if (kind >= 80 && kind < 92)
                total = $urandom_range(1, 11 + 4 * csrc);
            else if (kind >= 92)
                total = $urandom_range(1, 20);
            for (i = 0; i < total; i++)
            begin
                b = rhs_pkg::BYTE_W'($urandom_range(0, 255));
                if (kind < 92 && i == 0)
                begin
                    b[3:0] = csrc[3:0];
                    if ($urandom_range(0, 19) != 0)
                        b[7:6] = rhs_pkg::VERSION_OK;
                end
                else if (kind < 92 && i == 1 && $urandom_range(0, 9) != 0)
                begin
                    b[rhs_pkg::TYPE_W-1:0] = want_type;
                end
                queue_byte(b, i == total - 1);
            end
            queued += total;
        end
    endtask

    initial
    begin
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        sender_gap_pct = 29;
        reader_stall_pct = 70;
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hA1, 1'b0);
        for (i = 0; i < 10; i++)
            queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h4F, 1'b0);
        queue_byte(8'h55, 1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h21, 1'b0);
        queue_byte(8'h55, 1'b1);
        drain();

        write_reg(rhs_pkg::CFG_IDX_MAX_LEN, 12'd0);
        write_reg(rhs_pkg::CFG_IDX_EXP_TYPE, 12'd0);
        queue_random_traffic(7'd0, RUN_BYTES);
        drain();

        sender_gap_pct = 70;
        reader_stall_pct = 29;
        write_reg(rhs_pkg::CFG_IDX_MAX_LEN, 12'hFFF);
        write_reg(rhs_pkg::CFG_IDX_EXP_TYPE, 12'hFFF);
        queue_random_traffic(7'd127, RUN_BYTES);
        drain();

        write_reg(rhs_pkg::CFG_IDX_MAX_LEN, 12'd5);
        write_reg(rhs_pkg::CFG_IDX_EXP_TYPE, 12'(rhs_pkg::EXPECT_TYPE_RST));
        queue_random_traffic(rhs_pkg::EXPECT_TYPE_RST, RUN_BYTES);
        drain();

        sender_gap_pct = 0;
        reader_stall_pct = 0;
        run_len = rhs_pkg::CNT_W'($urandom_range(1, 40));
        run_type = rhs_pkg::TYPE_W'($urandom_range(0, 127));
        write_reg(rhs_pkg::CFG_IDX_MAX_LEN, run_len);
        write_reg(rhs_pkg::CFG_IDX_EXP_TYPE, 12'(run_type));
        queue_random_traffic(run_type, RUN_BYTES);
        drain();

        write_reg(rhs_pkg::CFG_IDX_MAX_LEN, rhs_pkg::MAX_LEN_RST);
        write_reg(rhs_pkg::CFG_IDX_EXP_TYPE, 12'(rhs_pkg::EXPECT_TYPE_RST));
        queue_random_traffic(rhs_pkg::EXPECT_TYPE_RST, RUN_BYTES);
        drain();

        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
